[sv/cba_pkg.sv]
// Shared constants for the channel borrowing allocator.
package cba_pkg;

  localparam int CFG_REGS     = 3;
  localparam int CFG_W        = 48;
  localparam int MASK_W       = 12;
  localparam int MASKED_CELLS = 12;
  localparam int CELL_W       = 4;
  localparam int CHAN_OUT_W   = 4;
  localparam int IN_TIME_W    = 32;

  localparam logic [1:0] CFG_NBR_1_4  = 2'd0;
  localparam logic [1:0] CFG_NBR_5_8  = 2'd1;
  localparam logic [1:0] CFG_NBR_9_12 = 2'd2;

  localparam logic [1:0] OUT_OWN     = 2'd0;
  localparam logic [1:0] OUT_BORROW  = 2'd1;
  localparam logic [1:0] OUT_BLOCKED = 2'd2;

endpackage

[sv/channel_borrowing_allocator.sv]
// Top level of the channel borrowing allocator.
//
//   channel  handshake         beat contents
//   in_      in_valid/in_stall   request_time, cell_req, hold_time
//   out_     out_valid/out_stall outcome, channel_number, lender_cell
//   cfg_     cfg_valid/cfg_ready index, 48-bit neighbor mask word
//
// A request runs a release sweep, which reads the slot memory one entry per
// cycle, then searches the own cell's slots and, when borrowing, counts the
// channels held by each cell and runs up to NUM_CELLS rounds of lender
// selection and slot search. Reset is synchronous and
// clears all slots and held channels. A waiting result holds the block only
// when the next result is ready to be loaded.
module channel_borrowing_allocator #(
  parameter int NUM_CELLS      = 12,
  parameter int SLOTS_PER_CELL = 5,
  parameter int REUSE_GROUPS   = 3,
  parameter int TIME_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_request_time,
  input  logic [3:0]  in_cell_req,
  input  logic [31:0] in_hold_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_outcome,
  output logic [3:0]  out_channel_number,
  output logic [3:0]  out_lender_cell,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int NUM_SLOTS = NUM_CELLS * SLOTS_PER_CELL;
  localparam int NCH       = REUSE_GROUPS * SLOTS_PER_CELL;
  localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCW       = $clog2(NUM_SLOTS + 1);
  localparam int CW        = $clog2(NUM_CELLS);
  localparam int KW        = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int GW        = (REUSE_GROUPS > 1) ? $clog2(REUSE_GROUPS) : 1;
  localparam int CHW       = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CNTW      = $clog2(NCH + 1);
  localparam int TB        = TIME_BITS;
  localparam int MW        = cba_pkg::CELL_W + TB;
  localparam int GRP0      = 1 % REUSE_GROUPS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REL, ST_BLK, ST_TRY, ST_CNT, ST_SEL, ST_DONE
  } state_t;

  state_t state_r;

  logic [cba_pkg::CFG_W-1:0] nbr_r [cba_pkg::CFG_REGS];
  logic [NUM_SLOTS-1:0]      busy_r;
  logic [NCH-1:0]            held_r [NUM_CELLS];
  logic [NUM_CELLS-1:0]      tried_r;
  logic [CNTW-1:0]           cnt_r [NUM_CELLS];
  logic [GW-1:0]             grp_tab [16];

  logic [TB-1:0]     now_r, end_r, hold_r;
  logic [3:0]        cell_r, owner_r;
  logic [GW-1:0]     ogrp_r;
  logic              borrow_r;
  logic [KW-1:0]     k_r;
  logic [CW-1:0]     j_r, best_r;
  logic [CNTW-1:0]   best_cnt_r;
  logic              found_r;
  logic [NCH-1:0]    blk_r;
  logic [NUM_CELLS-1:0] nmask_r;
  logic [SCW-1:0]    s_r;
  logic [KW-1:0]     sk_r;
  logic [GW-1:0]     sg_r;
  logic              rd_vld_r;
  logic [SW-1:0]     rd_slot_r;
  logic [CHW-1:0]    rd_ch_r;
  logic [1:0]        res_outcome_r;
  logic [3:0]        res_chan_r, res_lender_r;
  logic              out_valid_r;
  logic [1:0]        out_outcome_r;
  logic [3:0]        out_chan_r, out_lender_r;

  logic [MW-1:0]     rdata;
  logic [3:0]        rd_user;
  logic [TB-1:0]     rd_end;
  logic              rel_hit;
  logic [SW-1:0]     try_slot;
  logic [CHW-1:0]    try_ch;
  logic              grant, try_last, j_last;
  logic              cell_ok;
  logic [CW-1:0]     cidx;
  logic [cba_pkg::CFG_W*cba_pkg::CFG_REGS-1:0] cfg_all;
  logic [cba_pkg::MASK_W-1:0] raw_mask;
  logic [NUM_CELLS-1:0] mask_vec;
  logic [NCH-1:0]    nb_or;
  logic [TB:0]       end_sum;
  logic              cand, better;
  logic [CW-1:0]     best_nxt;
  logic              found_nxt;
  logic              load_out;

  for (genvar i = 0; i < 16; i++) begin : g_grp
    assign grp_tab[i] = GW'(i % REUSE_GROUPS);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_channel_number = out_chan_r;
  assign out_lender_cell    = out_lender_r;

  assign rd_user = rdata[MW-1:TB];
  assign rd_end  = rdata[TB-1:0];
  assign rel_hit = (state_r == ST_REL) && rd_vld_r && busy_r[rd_slot_r] && (rd_end <= now_r);

  assign try_slot = SW'((int'(owner_r) - 1) * SLOTS_PER_CELL + int'(k_r));
  assign try_ch   = CHW'(int'(ogrp_r) * SLOTS_PER_CELL + int'(k_r));
  assign grant    = (state_r == ST_TRY) && !busy_r[try_slot] && !blk_r[try_ch];
  assign try_last = (k_r == KW'(SLOTS_PER_CELL - 1));
  assign j_last   = (j_r == CW'(NUM_CELLS - 1));

  assign cell_ok  = (cell_r >= 4'd1) && (int'(cell_r) <= NUM_CELLS);
  assign cidx     = CW'(cell_r - 4'd1);
  assign cfg_all  = {nbr_r[2], nbr_r[1], nbr_r[0]};

  always_comb begin
    raw_mask = '0;
    if (cell_ok && (int'(cell_r) <= cba_pkg::MASKED_CELLS)) begin
      raw_mask = cfg_all[(int'(cell_r) - 1) * cba_pkg::MASK_W +: cba_pkg::MASK_W];
    end
    mask_vec = '0;
    nb_or    = '0;
    for (int j = 0; j < NUM_CELLS; j++) begin
      if (j < cba_pkg::MASKED_CELLS) begin
        mask_vec[j] = raw_mask[j];
      end
      if (mask_vec[j]) begin
        nb_or = nb_or | held_r[j];
      end
    end
  end

  assign end_sum   = {1'b0, hold_r} + {1'b0, now_r};
  assign cand      = nmask_r[j_r] && !tried_r[j_r];
  assign better    = !found_r || (cnt_r[j_r] < best_cnt_r);
  assign best_nxt  = (cand && better) ? j_r : best_r;
  assign found_nxt = found_r || cand;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  cba_slot_ram #(.DEPTH(NUM_SLOTS), .W(MW)) u_slots (
    .clk   (clk),
    .we    (grant),
    .waddr (try_slot),
    .wdata ({cell_r, end_r}),
    .raddr (s_r[SW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      tried_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < cba_pkg::CFG_REGS; i++) begin
        nbr_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CELLS; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cba_pkg::CFG_NBR_1_4:  nbr_r[0] <= cfg_data;
          cba_pkg::CFG_NBR_5_8:  nbr_r[1] <= cfg_data;
          cba_pkg::CFG_NBR_9_12: nbr_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= (state_r == ST_REL) && (int'(s_r) < NUM_SLOTS);
      if (rel_hit) begin
        busy_r[rd_slot_r] <= 1'b0;
        held_r[CW'(rd_user - 4'd1)][rd_ch_r] <= 1'b0;
      end
      if (grant) begin
        busy_r[try_slot] <= 1'b1;
        held_r[cidx][try_ch] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_REL;
          end
        end
        ST_REL: begin
          if (int'(s_r) == NUM_SLOTS) begin
            state_r <= ST_BLK;
          end
        end
        ST_BLK: begin
          state_r <= cell_ok ? ST_TRY : ST_DONE;
        end
        ST_TRY: begin
          if (grant) begin
            state_r <= ST_DONE;
          end else if (try_last) begin
            state_r <= borrow_r ? ST_SEL : ST_CNT;
          end
        end
        ST_CNT: begin
          if (j_last) begin
            tried_r <= '0;
            state_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (j_last) begin
            if (found_nxt) begin
              tried_r[best_nxt] <= 1'b1;
              state_r <= ST_TRY;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= s_r[SW-1:0];
    rd_ch_r   <= CHW'(int'(sg_r) * SLOTS_PER_CELL + int'(sk_r));
    if (load_out) begin
      out_outcome_r <= res_outcome_r;
      out_chan_r    <= res_chan_r;
      out_lender_r  <= res_lender_r;
    end
    if (grant) begin
      res_outcome_r <= borrow_r ? cba_pkg::OUT_BORROW : cba_pkg::OUT_OWN;
      res_chan_r    <= 4'(int'(try_ch) + 1);
      res_lender_r  <= owner_r;
    end
    case (state_r)
      ST_IDLE: begin
        now_r  <= TB'(in_request_time);
        hold_r <= TB'(in_hold_time);
        cell_r <= in_cell_req;
        s_r    <= '0;
        sk_r   <= '0;
        sg_r   <= GW'(GRP0);
      end
      ST_REL: begin
        if (int'(s_r) < NUM_SLOTS) begin
          s_r <= s_r + 1'b1;
          if (sk_r == KW'(SLOTS_PER_CELL - 1)) begin
            sk_r <= '0;
            sg_r <= (sg_r == GW'(REUSE_GROUPS - 1)) ? '0 : sg_r + 1'b1;
          end else begin
            sk_r <= sk_r + 1'b1;
          end
        end
      end
      ST_BLK: begin
        end_r         <= end_sum[TB] ? {TB{1'b1}} : end_sum[TB-1:0];
        blk_r         <= held_r[cidx] | nb_or;
        nmask_r       <= mask_vec;
        owner_r       <= cell_r;
        ogrp_r        <= grp_tab[cell_r];
        borrow_r      <= 1'b0;
        k_r           <= '0;
        res_outcome_r <= cba_pkg::OUT_BLOCKED;
        res_chan_r    <= '0;
        res_lender_r  <= '0;
      end
      ST_TRY: begin
        k_r     <= k_r + 1'b1;
        j_r     <= '0;
        found_r <= 1'b0;
      end
      ST_CNT: begin
        cnt_r[j_r] <= CNTW'($countones(held_r[j_r]));
        j_r        <= j_last ? '0 : j_r + 1'b1;
        found_r    <= 1'b0;
      end
      ST_SEL: begin
        j_r     <= j_r + 1'b1;
        best_r  <= best_nxt;
        found_r <= found_nxt;
        if (cand && better) begin
          best_cnt_r <= cnt_r[j_r];
        end
        if (j_last) begin
          owner_r  <= 4'(int'(best_nxt) + 1);
          ogrp_r   <= grp_tab[4'(int'(best_nxt) + 1)];
          borrow_r <= 1'b1;
          k_r      <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_try_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRY) |-> (owner_r >= 4'd1) && (int'(owner_r) <= NUM_CELLS))
    else $error("slot search runs on an owner outside the cell range");
  a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r == cba_pkg::OUT_BLOCKED)) |->
    (out_chan_r == 4'd0) && (out_lender_r == 4'd0))
    else $error("blocked beat carries a channel or lender");
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result beat raised outside the done state");
  a_own_lender: assert property (@(posedge clk) disable iff (!rst_n)
    grant && !borrow_r |-> (owner_r == cell_r))
    else $error("own grant from a foreign cell");
`endif

endmodule

[sv/cba_slot_ram.sv]
// Slot store: one write port, one read port with registered read data.
module cba_slot_ram #(
  parameter int DEPTH = 60,
  parameter int W     = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/tb_channel_borrowing_allocator.sv]
// Testbench for the channel borrowing allocator: random and directed requests checked by a predictor.
module tb_channel_borrowing_allocator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = 12;
  localparam int SPC = 5;
  localparam int NSLOT = 60;
  localparam int NCHAN = 15;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct packed {
    logic [31:0] req_time;
    logic [3:0]  cell_id;
    logic [31:0] hold;
  } call_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [3:0] chan;
    logic [3:0] lender;
  } grant_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [31:0] in_request_time, in_hold_time;
  logic [3:0] in_cell_req;
  logic out_valid, out_stall;
  logic [1:0] out_outcome;
  logic [3:0] out_channel_number, out_lender_cell;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;

  channel_borrowing_allocator u_top (.*);

  call_t pending_calls[$];
  grant_t expected_grants[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_wait = 0;
  int stall_wait = 0;
  int in_beats = 0;
  int in_seen = 0;
  int out_beats = 0;
  int out_seen = 0;
  logic [31:0] clock_now = 0;

  logic [47:0] nbr_word[3] = '{default: '0};
  logic slot_busy[NSLOT] = '{default: 1'b0};
  logic [3:0] slot_user[NSLOT];
  logic [31:0] slot_end[NSLOT];
  logic held[NCELL][NCHAN] = '{default: '{default: 1'b0}};

  function automatic int chan_of(int s);
    return ((s / SPC + 1) % 3) * SPC + (s % SPC) + 1;
  endfunction

  function automatic logic [11:0] mask_of(int c);
    logic [47:0] w;
    if (c < 1 || c > 12) return 12'd0;
    w = nbr_word[(c - 1) / 4] >> (((c - 1) % 4) * 12);
    return w[11:0];
  endfunction

  function automatic bit chan_free_for(int ch, int c);
    logic [11:0] m;
    m = mask_of(c);
    if (held[c - 1][ch - 1]) return 0;
    for (int j = 0; j < NCELL; j++)
      if (m[j] && held[j][ch - 1]) return 0;
    return 1;
  endfunction

  function automatic int take_slot(int owner, int c, logic [31:0] fin);
    int s, ch;
    for (int k = 0; k < SPC; k++) begin
      s = (owner - 1) * SPC + k;
      ch = chan_of(s);
      if (!slot_busy[s] && chan_free_for(ch, c)) begin
        slot_busy[s] = 1;
        slot_user[s] = 4'(c);
        slot_end[s] = fin;
        held[c - 1][ch - 1] = 1;
        return ch;
      end
    end
    return 0;
  endfunction

  function automatic grant_t allocate(call_t r);
    grant_t g;
    logic [32:0] sum;
    logic [31:0] fin;
    logic [11:0] m;
    bit tried[NCELL];
    int ch, best, bestc, cnt, c;
    bit found;
    g = '{cba_pkg::OUT_BLOCKED, 4'd0, 4'd0};
    c = r.cell_id;
    for (int s = 0; s < NSLOT; s++)
      if (slot_busy[s] && slot_end[s] <= r.req_time) begin
        held[slot_user[s] - 1][chan_of(s) - 1] = 0;
        slot_busy[s] = 0;
      end
    if (c < 1 || c > NCELL) return g;
    sum = {1'b0, r.req_time} + {1'b0, r.hold};
    fin = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    ch = take_slot(c, c, fin);
    if (ch != 0) return '{cba_pkg::OUT_OWN, ch[3:0], r.cell_id};
    m = mask_of(c);
    foreach (tried[j]) tried[j] = 0;
    forever begin
      found = 0;
      best = 0;
      bestc = 0;
      for (int j = 0; j < NCELL; j++) begin
        if (!m[j] || tried[j]) continue;
        cnt = 0;
        for (int k = 0; k < NCHAN; k++) cnt += held[j][k];
        if (!found || cnt < bestc) begin
          found = 1;
          best = j + 1;
          bestc = cnt;
        end
      end
      if (!found) break;
      tried[best - 1] = 1;
      ch = take_slot(best, c, fin);
      if (ch != 0) return '{cba_pkg::OUT_BORROW, ch[3:0], best[3:0]};
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver: one beat per queued call, with a random gap after each accepted beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_request_time <= '0;
      in_cell_req <= '0;
      in_hold_time <= '0;
      send_wait <= 0;
    end else if (in_valid && (in_seen != in_beats)) begin
      in_valid <= 0;
      in_seen <= in_beats;
      send_wait <= $urandom_range(0, 14);
    end else if (!in_valid) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_calls.size() > 0) begin
        in_valid <= 1;
        in_request_time <= pending_calls[0].req_time;
        in_cell_req <= pending_calls[0].cell_id;
        in_hold_time <= pending_calls[0].hold;
        void'(pending_calls.pop_front());
      end
    end
  end

  // Result side: a fresh stall length is drawn after every accepted beat.
  always @(negedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 0;
      stall_wait <= 0;
    end else if (out_seen != out_beats) begin
      w = $urandom_range(0, 14);
      out_seen <= out_beats;
      out_stall <= (w > 0);
      stall_wait <= (w > 0) ? w - 1 : 0;
    end else if (stall_wait > 0) begin
      out_stall <= 1;
      stall_wait <= stall_wait - 1;
    end else begin
      out_stall <= 0;
    end
  end

  // Monitor: predicts on each accepted request and checks each result beat.
  always @(posedge clk) begin
    grant_t g;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_grants = {expected_grants,
                           allocate('{in_request_time, in_cell_req, in_hold_time})};
        in_beats <= in_beats + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          g = expected_grants.pop_front();
          if (out_outcome != g.outcome) report_mismatch("outcome", out_outcome, g.outcome);
          if (out_channel_number != g.chan)
            report_mismatch("channel_number", out_channel_number, g.chan);
          if (out_lender_cell != g.lender)
            report_mismatch("lender_cell", out_lender_cell, g.lender);
        end
        out_beats <= out_beats + 1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_mask(input logic [1:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    nbr_word[idx] = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_calls.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_call(input logic [31:0] dt, input logic [3:0] c, input logic [31:0] h);
    call_t item;
    clock_now = (clock_now + dt < clock_now) ? clock_now : clock_now + dt;
    item = '{clock_now, c, h};
    pending_calls = {pending_calls, item};
  endtask

  task automatic random_mask_set(input int style);
    logic [47:0] w;
    for (int i = 0; i < 3; i++) begin
      case (style)
        0: w = 48'd0;
        1: w = '1;
        default: w = 48'({$urandom, $urandom});
      endcase
      write_mask(2'(i), w);
    end
  endtask

  initial begin
    logic [31:0] h;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = cba_pkg::CFG_NBR_1_4;
    cfg_data = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset masks, out-of-range cells, saturation, exhaustion.
    queue_call(0, 4'd0, 32'h1_0000);
    queue_call(1, 4'd13, 32'h1_0000);
    queue_call(1, 4'd15, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) queue_call(0, 4'd1, 32'hFFFF_FFFF);
    wait_drained();
    random_mask_set(1);
    for (int i = 0; i < 8; i++) queue_call(0, 4'd2 + i[3:0], 32'h10_0000);
    for (int i = 0; i < 7; i++) queue_call(0, 4'd12, 32'h10_0000);
    queue_call(32'h20_0000, 4'd12, 32'd0);
    wait_drained();
    write_mask(cba_pkg::CFG_NBR_1_4, 48'h002_004_00A_006);
    write_mask(cba_pkg::CFG_NBR_5_8, 48'hFFF_000_F0F_0F0);
    write_mask(cba_pkg::CFG_NBR_9_12, 48'h800_FFF_401_200);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        wait_drained();
        random_mask_set(phase == 7 ? 0 : (phase == 3 ? 1 : 2));
      end
      for (int n = 0; n < 240; n++) begin
        h = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 32'h40_0000);
        queue_call($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h8_0000),
                   4'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 12)),
                   h);
        if (clock_now > 32'hF000_0000 && $urandom_range(0, 3) == 0) clock_now = $urandom;
      end
    end
    wait_drained();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
